// ===== design/ptgr_pkg.sv =====
`timescale 1ns / 1ps

package ptgr_pkg;

    localparam int MAX_CELLS_DEF   = 65536;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SAMPLES         = 8;

    // round(cos(45 deg) * 2^30)
    localparam logic [29:0] COS45_Q30 = 30'd759250125;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_INV_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_INV_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_COLUMNS     = 3'd4;
    localparam logic [2:0] CFG_ROWS        = 3'd5;
    localparam logic [2:0] CFG_MODE        = 3'd6;
    localparam logic [2:0] CFG_RADIUS      = 3'd7;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_MAX   = 2'd0,
        MODE_MIN   = 2'd1,
        MODE_COUNT = 2'd2,
        MODE_OFF   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_COORD,
        ST_MUL,
        ST_LOC,
        ST_CELL,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_RD_WAIT,
        ST_RD_DATA,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [31:0]        inv_width;
        logic [31:0]        inv_height;
        logic [8:0]         columns;
        logic [8:0]         rows;
        mode_t              mode;
        logic [30:0]        radius;
    } cfg_t;

    // One classified command as it waits between front and back
    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        rd;
        logic [30:0]        diag;
    } job_t;

    typedef struct packed {
        logic       ok;
        logic [8:0] idx;
    } loc_t;

    // Offset of sample k on the circle; axis offsets are exact, diagonals use diag
    function automatic logic signed [32:0] circle_off(
        logic [2:0] k, logic [30:0] r, logic [30:0] diag);
        logic signed [32:0] res;
        case (k)
            3'd0:          res = $signed({2'b00, r});
            3'd1, 3'd7:    res = $signed({2'b00, diag});
            3'd3, 3'd5:    res = -$signed({2'b00, diag});
            3'd4:          res = -$signed({2'b00, r});
            default:       res = '0;
        endcase
        return res;
    endfunction

    // Turn the split product of offset and reciprocal into an index below n
    function automatic loc_t locate(logic [42:0] hi, logic [55:0] lo, logic neg,
                                    logic inv_zero, logic [8:0] n);
        loc_t        res;
        logic [44:0] q;
        logic [23:0] frac;
        q       = {2'b00, hi} + 45'(lo[55:24]);
        frac    = lo[23:0];
        res.ok  = 1'b1;
        res.idx = q[8:0];
        if (n == 9'd0)
        begin
            res.ok = 1'b0;
        end
        else if (neg && !inv_zero)
        begin
            res.ok = 1'b0;
        end
        else if (q == 45'(n) && frac == 24'd0)
        begin
            res.idx = n - 9'd1;
        end
        else if (q >= 45'(n))
        begin
            res.ok = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== design/point_to_grid_raster_reduce_core.sv =====
`timescale 1ns / 1ps
// An add runs coordinate, multiply, locate and cell steps per sample, plus a memory read and
//   write for each updated sample; a read waits on the registered memory output.
// The back sequencer takes one command at a time, with one memory read-modify-write per
//   updated sample; a dropped sample skips the memory.
// A clear sweeps the cell memory one entry per cycle.
// Reset (rst_n, asynchronous, active low) runs the same sweep; s_tready
//   stays low until it ends, configuration writes are taken throughout.

module point_to_grid_raster_reduce_core #(
    parameter int MAX_CELLS   = ptgr_pkg::MAX_CELLS_DEF,
    parameter int QUEUE_DEPTH = ptgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // cmd
    input  logic [111:0] s_tdata,   // point_x, point_y, point_z, read_cell
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata    // status, cell_value, cell_empty, zero fill
);

    ptgr_pkg::cfg_t cfg_reg;
    ptgr_pkg::job_t push_job, pop_job;
    logic           push_valid, push_ready, pop_valid, pop, init_done;
    logic           status, cell_empty;
    logic [31:0]    cell_value;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.inv_width  <= 32'd65536;
            cfg_reg.inv_height <= 32'd65536;
            cfg_reg.columns    <= 9'd256;
            cfg_reg.rows       <= 9'd256;
            cfg_reg.mode       <= ptgr_pkg::MODE_MAX;
            cfg_reg.radius     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptgr_pkg::CFG_ORIGIN_X:   cfg_reg.origin_x   <= cfg_data;
                ptgr_pkg::CFG_ORIGIN_Y:   cfg_reg.origin_y   <= cfg_data;
                ptgr_pkg::CFG_INV_WIDTH:  cfg_reg.inv_width  <= cfg_data;
                ptgr_pkg::CFG_INV_HEIGHT: cfg_reg.inv_height <= cfg_data;
                ptgr_pkg::CFG_COLUMNS:    cfg_reg.columns    <= cfg_data[8:0];
                ptgr_pkg::CFG_ROWS:       cfg_reg.rows       <= cfg_data[8:0];
                ptgr_pkg::CFG_MODE:       cfg_reg.mode       <= ptgr_pkg::mode_t'(cfg_data[1:0]);
                ptgr_pkg::CFG_RADIUS:     cfg_reg.radius     <= cfg_data[30:0];
                default:                  cfg_reg.radius     <= cfg_reg.radius;
            endcase
        end
    end

    ptgr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .radius     (cfg_reg.radius),
        .init_done  (init_done),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    ptgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    ptgr_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_valid  (pop_valid),
        .job        (pop_job),
        .job_pop    (pop),
        .init_done  (init_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .status     (status),
        .cell_value (cell_value),
        .cell_empty (cell_empty)
    );

    assign m_tdata = {6'd0, cell_empty, cell_value, status};

endmodule

// ===== design/ptgr_ram.sv =====
`timescale 1ns / 1ps

module ptgr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ptgr_queue.sv =====
`timescale 1ns / 1ps

module ptgr_queue #(
    parameter int DEPTH = ptgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ptgr_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop,
    output ptgr_pkg::job_t pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ptgr_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = slot_reg[rd_ptr_reg];

    // Store beats
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/ptgr_front.sv =====
`timescale 1ns / 1ps

module ptgr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     s_tuser,
    input  logic [111:0]   s_tdata,
    input  logic [30:0]    radius,
    input  logic           init_done,
    output logic           push_valid,
    input  logic           push_ready,
    output ptgr_pkg::job_t push_job
);

    logic                 stage_valid_reg;
    ptgr_pkg::cmd_t       cmd_reg;
    logic signed [31:0]   px_reg, py_reg, pz_reg;
    logic [15:0]          rd_reg;
    logic [44:0]          prod_hi_reg;
    logic [45:0]          prod_lo_reg;
    logic [61:0]          diag_sum;
    logic                 accept;

    assign s_tready = init_done && (!stage_valid_reg || push_ready);
    assign accept   = s_tvalid && s_tready;

    // Capture beat, split the diagonal product of the radius
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= ptgr_pkg::cmd_t'(s_tuser);
            px_reg      <= s_tdata[31:0];
            py_reg      <= s_tdata[63:32];
            pz_reg      <= s_tdata[95:64];
            rd_reg      <= s_tdata[111:96];
            prod_hi_reg <= radius[30:16] * ptgr_pkg::COS45_Q30;
            prod_lo_reg <= radius[15:0] * ptgr_pkg::COS45_Q30;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // Round r*cos45 to nearest, halves up
    assign diag_sum = {prod_hi_reg, 16'd0} + {16'd0, prod_lo_reg} + (62'd1 << 29);

    assign push_valid    = stage_valid_reg;
    assign push_job.cmd  = cmd_reg;
    assign push_job.px   = px_reg;
    assign push_job.py   = py_reg;
    assign push_job.pz   = pz_reg;
    assign push_job.rd   = rd_reg;
    assign push_job.diag = diag_sum[60:30];

endmodule

// ===== design/ptgr_back.sv =====
`timescale 1ns / 1ps

module ptgr_back #(
    parameter int MAX_CELLS = ptgr_pkg::MAX_CELLS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ptgr_pkg::cfg_t  cfg,
    input  logic            job_valid,
    input  ptgr_pkg::job_t  job,
    output logic            job_pop,
    output logic            init_done,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            status,
    output logic [31:0]     cell_value,
    output logic            cell_empty
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    ptgr_pkg::state_t   state_reg, state_next;
    ptgr_pkg::job_t     job_reg;
    logic [2:0]         k_reg;
    logic signed [35:0] dx_reg, dy_reg;
    logic [42:0]        hx_reg, hy_reg;
    logic [55:0]        lx_reg, ly_reg;
    logic               nx_reg, ny_reg;
    logic               loc_ok_reg;
    logic [18:0]        cell_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               res_status_reg, res_empty_reg;
    logic [31:0]        res_value_reg;
    logic               m_tvalid_reg, status_reg, empty_reg;
    logic [31:0]        value_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [32:0]        ram_wdata, ram_rdata;
    logic               load_out, last_sample, cell_ok, rd_in_range, clr_last;
    logic [18:0]        cell_calc;
    logic signed [33:0] sx, sy;
    ptgr_pkg::loc_t     loc_x, loc_y;
    logic               old_valid;
    logic signed [31:0] old_value, new_value;

    ptgr_ram #(
        .WIDTH (33),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sample coordinates and cell arithmetic
    assign sx = 34'(job_reg.px) + 34'(ptgr_pkg::circle_off(k_reg, cfg.radius, job_reg.diag));
    assign sy = 34'(job_reg.py) +
                34'(ptgr_pkg::circle_off(k_reg + 3'd6, cfg.radius, job_reg.diag));
    assign loc_x = ptgr_pkg::locate(hx_reg, lx_reg, nx_reg, cfg.inv_width == '0,
                                    cfg.columns);
    assign loc_y = ptgr_pkg::locate(hy_reg, ly_reg, ny_reg, cfg.inv_height == '0,
                                    cfg.rows);
    assign cell_calc   = 19'(loc_y.idx) * 19'(cfg.columns) + 19'(loc_x.idx);
    assign cell_ok     = loc_ok_reg && (21'(cell_reg) < 21'(MAX_CELLS));
    assign last_sample = (cfg.radius == '0) || (k_reg == 3'd7);
    assign rd_in_range = (21'(job_reg.rd) < 21'(MAX_CELLS));
    assign clr_last    = (clr_cnt_reg == AW'(MAX_CELLS - 1));
    assign load_out    = !m_tvalid_reg || m_tready;

    // Fold the sample into the stored cell
    assign old_valid = ram_rdata[32];
    assign old_value = ram_rdata[31:0];
    always_comb
    begin
        new_value = old_value;
        case (cfg.mode)
            ptgr_pkg::MODE_MAX:
            begin
                if (!old_valid || job_reg.pz > old_value)
                begin
                    new_value = job_reg.pz;
                end
            end
            ptgr_pkg::MODE_MIN:
            begin
                if (!old_valid || job_reg.pz < old_value)
                begin
                    new_value = job_reg.pz;
                end
            end
            ptgr_pkg::MODE_COUNT:
            begin
                if (!old_valid)
                begin
                    new_value = 32'sd1;
                end
                else if (old_value != 32'sh7FFF_FFFF)
                begin
                    new_value = old_value + 32'sd1;
                end
            end
            default:
            begin
                new_value = old_value;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptgr_pkg::ST_INIT_CLR:
            begin
                if (clr_last)
                begin
                    state_next = ptgr_pkg::ST_IDLE;
                end
            end
            ptgr_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    case (job.cmd)
                        ptgr_pkg::CMD_ADD:   state_next = ptgr_pkg::ST_COORD;
                        ptgr_pkg::CMD_READ:  state_next = ptgr_pkg::ST_RD_WAIT;
                        ptgr_pkg::CMD_CLEAR: state_next = ptgr_pkg::ST_CLEAR;
                        default:             state_next = ptgr_pkg::ST_DONE;
                    endcase
                end
            end
            ptgr_pkg::ST_COORD:   state_next = ptgr_pkg::ST_MUL;
            ptgr_pkg::ST_MUL:     state_next = ptgr_pkg::ST_LOC;
            ptgr_pkg::ST_LOC:     state_next = ptgr_pkg::ST_CELL;
            ptgr_pkg::ST_CELL:
            begin
                if (cell_ok && cfg.mode != ptgr_pkg::MODE_OFF)
                begin
                    state_next = ptgr_pkg::ST_UPD_RD;
                end
                else if (last_sample)
                begin
                    state_next = ptgr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ptgr_pkg::ST_COORD;
                end
            end
            ptgr_pkg::ST_UPD_RD:  state_next = ptgr_pkg::ST_UPD_WR;
            ptgr_pkg::ST_UPD_WR:
            begin
                state_next = last_sample ? ptgr_pkg::ST_DONE : ptgr_pkg::ST_COORD;
            end
            ptgr_pkg::ST_RD_WAIT:
            begin
                state_next = rd_in_range ? ptgr_pkg::ST_RD_DATA : ptgr_pkg::ST_DONE;
            end
            ptgr_pkg::ST_RD_DATA: state_next = ptgr_pkg::ST_DONE;
            ptgr_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ptgr_pkg::ST_DONE;
                end
            end
            ptgr_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ptgr_pkg::ST_IDLE;
                end
            end
            default:              state_next = ptgr_pkg::ST_IDLE;
        endcase
    end

    // Memory control and queue pop
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = AW'(cell_reg);
        ram_wdata = {1'b1, new_value};
        job_pop   = 1'b0;
        case (state_reg)
            ptgr_pkg::ST_INIT_CLR, ptgr_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            ptgr_pkg::ST_IDLE:
            begin
                job_pop = job_valid;
            end
            ptgr_pkg::ST_UPD_WR:
            begin
                ram_we = 1'b1;
            end
            ptgr_pkg::ST_RD_WAIT:
            begin
                ram_addr = AW'(job_reg.rd);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ptgr_pkg::ST_INIT_CLR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Sweep counter for reset and clear
            if (state_reg == ptgr_pkg::ST_INIT_CLR || state_reg == ptgr_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            // Output register
            if (state_reg == ptgr_pkg::ST_DONE && load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ptgr_pkg::ST_IDLE:
            begin
                job_reg        <= job;
                k_reg          <= '0;
                res_status_reg <= 1'b0;
                res_value_reg  <= '0;
                res_empty_reg  <= (job.cmd == ptgr_pkg::CMD_READ);
            end
            ptgr_pkg::ST_COORD:
            begin
                dx_reg <= 36'(sx) - 36'(cfg.origin_x);
                dy_reg <= 36'(cfg.origin_y) - 36'(sy);
            end
            ptgr_pkg::ST_MUL:
            begin
                nx_reg <= dx_reg[35];
                ny_reg <= dy_reg[35];
                hx_reg <= dx_reg[34:24] * cfg.inv_width;
                lx_reg <= dx_reg[23:0] * cfg.inv_width;
                hy_reg <= dy_reg[34:24] * cfg.inv_height;
                ly_reg <= dy_reg[23:0] * cfg.inv_height;
            end
            ptgr_pkg::ST_LOC:
            begin
                // Cell index follows the located row and column
                loc_ok_reg <= loc_x.ok && loc_y.ok;
                cell_reg   <= cell_calc;
            end
            default:
            begin
            end
        endcase
        // Flag a dropped sample and step to the next one
        if (state_reg == ptgr_pkg::ST_CELL)
        begin
            if (!cell_ok)
            begin
                res_status_reg <= 1'b1;
            end
            if (!(cell_ok && cfg.mode != ptgr_pkg::MODE_OFF))
            begin
                k_reg <= k_reg + 3'd1;
            end
        end
        if (state_reg == ptgr_pkg::ST_UPD_WR)
        begin
            k_reg <= k_reg + 3'd1;
        end
        // Read result
        if (state_reg == ptgr_pkg::ST_RD_DATA)
        begin
            res_empty_reg <= !old_valid;
            res_value_reg <= old_valid ? old_value : '0;
        end
        if (state_reg == ptgr_pkg::ST_DONE && load_out)
        begin
            status_reg <= res_status_reg;
            value_reg  <= res_value_reg;
            empty_reg  <= res_empty_reg;
        end
    end

    assign init_done  = (state_reg != ptgr_pkg::ST_INIT_CLR);
    assign m_tvalid   = m_tvalid_reg;
    assign status     = status_reg;
    assign cell_value = value_reg;
    assign cell_empty = empty_reg;

endmodule

// ===== design/ptgr_checker.sv =====
`timescale 1ns / 1ps

module ptgr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);

    logic [7:0] open_reg;

    // Track beats taken in but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result without an item taken in
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> open_reg != 8'd0)
        else $error("result with no open item");

    // An empty cell reads as zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[32:1] == 32'd0)
        else $error("empty cell with nonzero value");

    // Status and empty belong to different commands
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
        else $error("status and empty both set");

endmodule

bind point_to_grid_raster_reduce_core ptgr_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
